// File: rtl/core/risc_decode_execute_core_assert.svh
// Assertion macros shared by the core's RTL.
`ifndef RISC_DECODE_EXECUTE_CORE_ASSERT_SVH
`define RISC_DECODE_EXECUTE_CORE_ASSERT_SVH

`ifndef ASSERT_OFF

// Same-cycle implication, disabled while reset is asserted.
`define RDEC_ASSERT_IMP(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define RDEC_ASSERT_NXT(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
    else $error(msg);

`else

`define RDEC_ASSERT_IMP(lbl, clk_s, rst_s, ante, cons, msg)
`define RDEC_ASSERT_NXT(lbl, clk_s, rst_s, ante, cons, msg)

`endif

`endif

// File: rtl/core/rdec_pkg.sv
package rdec_pkg;

  // Opcode field, bits 31..26 of the instruction.
  localparam logic [5:0] OP_NOP  = 6'h00;
  localparam logic [5:0] OP_ADDI = 6'h14;
  localparam logic [5:0] OP_ADD  = 6'h10;
  localparam logic [5:0] OP_SUB  = 6'h08;
  localparam logic [5:0] OP_MUL  = 6'h0C;
  localparam logic [5:0] OP_ANDI = 6'h04;
  localparam logic [5:0] OP_ORI  = 6'h0A;
  localparam logic [5:0] OP_BEQ  = 6'h02;
  localparam logic [5:0] OP_BNE  = 6'h03;
  localparam logic [5:0] OP_LW   = 6'h20;
  localparam logic [5:0] OP_SW   = 6'h28;
  localparam logic [5:0] OP_HALT = 6'h3F;

  localparam logic KIND_EXEC    = 1'b0;
  localparam logic KIND_PRELOAD = 1'b1;

  localparam logic [2:0] STAT_OK      = 3'd0;
  localparam logic [2:0] STAT_HALT    = 3'd1;
  localparam logic [2:0] STAT_BAD_OP  = 3'd2;
  localparam logic [2:0] STAT_LD_OOB  = 3'd3;
  localparam logic [2:0] STAT_ST_OOB  = 3'd4;
  localparam logic [2:0] STAT_PC_OOB  = 3'd5;
  localparam logic [2:0] STAT_STOPPED = 3'd6;

  typedef enum logic [3:0] {
    CLS_NOP,
    CLS_ADDI,
    CLS_ADD,
    CLS_SUB,
    CLS_MUL,
    CLS_ANDI,
    CLS_ORI,
    CLS_BEQ,
    CLS_BNE,
    CLS_LW,
    CLS_SW,
    CLS_HALT,
    CLS_BAD,
    CLS_PRELOAD
  } cls_t;

  // One classified word as it sits in the queue.
  typedef struct packed {
    cls_t        cls;
    logic [4:0]  rd;
    logic [4:0]  ra;
    logic [4:0]  rs2;
    logic [15:0] imm;
    logic [15:0] pl_addr;
    logic [7:0]  pl_byte;
  } ent_t;

  typedef struct packed {
    logic rd_en;
    logic wr_word;
    logic wr_byte;
  } dmem_ctl_t;

endpackage

// File: rtl/core/rdec_ram.sv
module rdec_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem_q[raddr];
    end
  end

endmodule

// File: rtl/core/rdec_front.sv
`include "risc_decode_execute_core_assert.svh"

module rdec_front import rdec_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_item_kind,
  input  logic [31:0] in_instruction,
  input  logic [15:0] in_preload_address,
  input  logic [7:0]  in_preload_byte,
  input  logic        hold,
  output logic        hd_valid,
  output ent_t        hd,
  input  logic        pop
);

  localparam int QDEPTH = 2;
  localparam int QAW = $clog2(QDEPTH);
  localparam int CW = $clog2(QDEPTH + 1);

  function automatic ent_t classify(input logic kind, input logic [31:0] ins,
                                    input logic [15:0] pa, input logic [7:0] pb);
    ent_t       e;
    logic [5:0] op;
    op        = ins[31:26];
    e.rd      = ins[25:21];
    e.ra      = ins[20:16];
    e.rs2     = ins[15:11];
    e.imm     = ins[15:0];
    e.pl_addr = pa;
    e.pl_byte = pb;
    case (op)
      OP_NOP:  e.cls = CLS_NOP;
      OP_ADDI: e.cls = CLS_ADDI;
      OP_ADD:  e.cls = CLS_ADD;
      OP_SUB:  e.cls = CLS_SUB;
      OP_MUL:  e.cls = CLS_MUL;
      OP_ANDI: e.cls = CLS_ANDI;
      OP_ORI:  e.cls = CLS_ORI;
      OP_BEQ:  e.cls = CLS_BEQ;
      OP_BNE:  e.cls = CLS_BNE;
      OP_LW:   e.cls = CLS_LW;
      OP_SW:   e.cls = CLS_SW;
      OP_HALT: e.cls = CLS_HALT;
      default: e.cls = CLS_BAD;
    endcase
    // branches and stores read rD as their second operand
    if (op inside {OP_BEQ, OP_BNE, OP_SW}) begin
      e.rs2 = ins[25:21];
    end
    if (kind == KIND_PRELOAD) begin
      e.cls = CLS_PRELOAD;
    end
    return e;
  endfunction

  ent_t           q_r [QDEPTH];
  logic [QAW-1:0] wptr_r, wptr_nxt;
  logic [QAW-1:0] rptr_r, rptr_nxt;
  logic [CW-1:0]  count_r, count_nxt;
  logic           push;

  assign in_stall = hold || (count_r == CW'(QDEPTH));
  assign push     = in_valid && !in_stall;
  assign hd_valid = (count_r != '0);
  assign hd       = q_r[rptr_r];

  always_comb begin
    wptr_nxt  = push ? wptr_r + 1'b1 : wptr_r;
    rptr_nxt  = pop ? rptr_r + 1'b1 : rptr_r;
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      wptr_r  <= wptr_nxt;
      rptr_r  <= rptr_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wptr_r] <= classify(in_item_kind, in_instruction, in_preload_address,
                              in_preload_byte);
    end
  end

  `RDEC_ASSERT_IMP(a_q_bound, clk, rst_n, 1'b1, count_r <= CW'(QDEPTH), "queue overfilled")
  `RDEC_ASSERT_IMP(a_q_pop, clk, rst_n, pop, count_r != '0, "pop from empty queue")
  `RDEC_ASSERT_NXT(a_q_push, clk, rst_n, push && !pop, hd_valid, "pushed word lost")

endmodule

// File: rtl/core/rdec_dmem.sv
module rdec_dmem import rdec_pkg::*; #(
  parameter int MEM_BYTES = 65536,
  localparam int AW = $clog2(MEM_BYTES)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  dmem_ctl_t     ctl,
  input  logic [AW-1:0] addr,
  input  logic [31:0]   wdata,
  output logic [31:0]   rdata,
  output logic          busy
);

  // Four byte banks, byte address a lives in bank a[1:0], row a >> 2.
  localparam int LANES = 4;
  localparam int RW = AW - 2;
  localparam int BANK_DEPTH = (MEM_BYTES + 3) / 4;
  localparam logic [RW-1:0] LAST_ROW = RW'(BANK_DEPTH - 1);

  logic          clearing_r, clearing_nxt;
  logic [RW-1:0] clr_row_r, clr_row_nxt;
  logic [1:0]    off, off_r;
  logic [RW-1:0] row0, row1;
  logic [7:0]    bank_q [LANES];

  assign off  = addr[1:0];
  assign row0 = addr[AW-1:2];
  assign row1 = row0 + 1'b1;
  assign busy = clearing_r;

  for (genvar b = 0; b < LANES; b++) begin : g_bank
    logic [1:0]    lane;
    logic [1:0]    k;
    logic [RW-1:0] row;
    logic          we;
    logic [RW-1:0] wa;
    logic [7:0]    wd;

    // lanes below the start offset hold the wrapped bytes of the next row
    assign lane = 2'(b);
    assign k    = lane - off;
    assign row  = (lane < off) ? row1 : row0;
    assign we   = clearing_r || ctl.wr_word || (ctl.wr_byte && (off == lane));
    assign wa   = clearing_r ? clr_row_r : row;
    assign wd   = clearing_r  ? 8'h00 :
                  ctl.wr_byte ? wdata[7:0] : wdata[{k, 3'b000} +: 8];

    rdec_ram #(
      .WIDTH (8),
      .DEPTH (BANK_DEPTH)
    ) u_ram (
      .clk   (clk),
      .we    (we),
      .waddr (wa),
      .wdata (wd),
      .re    (ctl.rd_en),
      .raddr (row),
      .rdata (bank_q[b])
    );
  end

  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      rdata[8*i +: 8] = bank_q[2'(i) + off_r];
    end
  end

  always_comb begin
    clearing_nxt = clearing_r;
    clr_row_nxt  = clr_row_r;
    if (clearing_r) begin
      if (clr_row_r == LAST_ROW) begin
        clearing_nxt = 1'b0;
      end else begin
        clr_row_nxt = clr_row_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r <= 1'b1;
      clr_row_r  <= '0;
    end else begin
      clearing_r <= clearing_nxt;
      clr_row_r  <= clr_row_nxt;
    end
    if (ctl.rd_en) begin
      off_r <= off;
    end
  end

endmodule

// File: rtl/core/rdec_back.sv
`include "risc_decode_execute_core_assert.svh"

module rdec_back import rdec_pkg::*; #(
  parameter int MEM_BYTES = 65536,
  localparam int AW = $clog2(MEM_BYTES)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          hd_valid,
  input  ent_t          hd,
  output logic          pop,
  output dmem_ctl_t     mem_ctl,
  output logic [AW-1:0] mem_addr,
  output logic [31:0]   mem_wdata,
  input  logic [31:0]   mem_rdata,
  output logic          out_valid,
  input  logic          out_stall,
  output logic [2:0]    out_status,
  output logic          out_stopped,
  output logic [31:0]   out_next_pc,
  output logic          out_reg_written,
  output logic [4:0]    out_reg_index,
  output logic [31:0]   out_reg_value
);

  typedef enum logic [1:0] {S_ISSUE, S_EXEC, S_LOAD} state_t;

  localparam logic [31:0] MEM_LIMIT = 32'(MEM_BYTES - 4);
  localparam logic [31:0] MEM_SIZE  = 32'(MEM_BYTES);

  state_t      state_r, state_nxt;
  ent_t        cur_r, cur_nxt;
  logic [31:0] pc_r, pc_nxt;
  logic        run_r, run_nxt;
  logic [31:0] rf_vld_r, rf_vld_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [2:0]  out_status_r, out_status_nxt;
  logic        out_stopped_r, out_stopped_nxt;
  logic [31:0] out_next_pc_r, out_next_pc_nxt;
  logic        out_reg_written_r, out_reg_written_nxt;
  logic [4:0]  out_reg_index_r, out_reg_index_nxt;
  logic [31:0] out_reg_value_r, out_reg_value_nxt;

  logic [31:0] rf_a_q, rf_b_q, a_val, b_val;
  logic        rf_we;
  logic [31:0] sext, zext, pc_inc, br_tgt, eff, prod, pl_addr32;
  logic        eff_ok, pc_ok, pl_ok, out_free, commit;

  logic [2:0]  x_status;
  logic        x_run, x_wr, x_load, x_st, x_pl;
  logic [31:0] x_pc, x_val;
  logic [4:0]  x_idx;

  logic [2:0]  c_status;
  logic        c_run, c_wr;
  logic [31:0] c_pc, c_val;
  logic [4:0]  c_idx;

  // two copies of the register file give the two read ports
  rdec_ram #(.WIDTH(32), .DEPTH(32)) u_rf_a (
    .clk   (clk),
    .we    (rf_we),
    .waddr (c_idx),
    .wdata (c_val),
    .re    (pop),
    .raddr (hd.ra),
    .rdata (rf_a_q)
  );

  rdec_ram #(.WIDTH(32), .DEPTH(32)) u_rf_b (
    .clk   (clk),
    .we    (rf_we),
    .waddr (c_idx),
    .wdata (c_val),
    .re    (pop),
    .raddr (hd.rs2),
    .rdata (rf_b_q)
  );

  // never-written registers read as zero
  assign a_val = rf_vld_r[cur_r.ra]  ? rf_a_q : '0;
  assign b_val = rf_vld_r[cur_r.rs2] ? rf_b_q : '0;

  assign sext      = {{16{cur_r.imm[15]}}, cur_r.imm};
  assign zext      = {16'h0000, cur_r.imm};
  assign pc_inc    = pc_r + 32'd4;
  assign br_tgt    = pc_inc + {sext[29:0], 2'b00};
  assign eff       = a_val + sext;
  assign eff_ok    = (eff <= MEM_LIMIT);
  assign pc_ok     = (pc_r <= MEM_LIMIT);
  assign pl_addr32 = {16'h0000, cur_r.pl_addr};
  assign pl_ok     = (pl_addr32 < MEM_SIZE);
  assign prod      = a_val * b_val;
  assign out_free  = !out_valid_r || !out_stall;

  assign mem_addr  = (cur_r.cls == CLS_PRELOAD) ? pl_addr32[AW-1:0] : eff[AW-1:0];
  assign mem_wdata = (cur_r.cls == CLS_PRELOAD) ? {24'h000000, cur_r.pl_byte} : b_val;

  always_comb begin
    x_status = STAT_OK;
    x_run    = run_r;
    x_pc     = pc_r;
    x_wr     = 1'b0;
    x_idx    = '0;
    x_val    = '0;
    x_load   = 1'b0;
    x_st     = 1'b0;
    x_pl     = 1'b0;
    if (cur_r.cls == CLS_PRELOAD) begin
      x_pl = pl_ok;
    end else if (!run_r) begin
      x_status = STAT_STOPPED;
    end else if (!pc_ok) begin
      x_run    = 1'b0;
      x_status = STAT_PC_OOB;
    end else begin
      x_pc = pc_inc;
      case (cur_r.cls)
        CLS_ADDI: begin
          x_wr  = 1'b1;
          x_idx = cur_r.rd;
          x_val = a_val + sext;
        end
        CLS_ADD: begin
          x_wr  = 1'b1;
          x_idx = cur_r.rd;
          x_val = a_val + b_val;
        end
        CLS_SUB: begin
          x_wr  = 1'b1;
          x_idx = cur_r.rd;
          x_val = a_val - b_val;
        end
        CLS_MUL: begin
          x_wr  = 1'b1;
          x_idx = cur_r.rd;
          x_val = prod;
        end
        CLS_ANDI: begin
          x_wr  = 1'b1;
          x_idx = cur_r.rd;
          x_val = a_val & zext;
        end
        CLS_ORI: begin
          x_wr  = 1'b1;
          x_idx = cur_r.rd;
          x_val = a_val | zext;
        end
        CLS_BEQ: begin
          if (a_val == b_val) begin
            x_pc = br_tgt;
          end
        end
        CLS_BNE: begin
          if (a_val != b_val) begin
            x_pc = br_tgt;
          end
        end
        CLS_LW: begin
          if (eff_ok) begin
            x_load = 1'b1;
          end else begin
            x_run    = 1'b0;
            x_status = STAT_LD_OOB;
          end
        end
        CLS_SW: begin
          if (eff_ok) begin
            x_st = 1'b1;
          end else begin
            x_run    = 1'b0;
            x_status = STAT_ST_OOB;
          end
        end
        CLS_HALT: begin
          x_run    = 1'b0;
          x_status = STAT_HALT;
        end
        CLS_BAD: begin
          x_run    = 1'b0;
          x_status = STAT_BAD_OP;
        end
        default: begin
        end
      endcase
    end
  end

  // a load finishes in S_LOAD with the word from the registered memory read
  always_comb begin
    if (state_r == S_LOAD) begin
      c_status = STAT_OK;
      c_run    = run_r;
      c_pc     = pc_inc;
      c_wr     = 1'b1;
      c_idx    = cur_r.rd;
      c_val    = mem_rdata;
    end else begin
      c_status = x_status;
      c_run    = x_run;
      c_pc     = x_pc;
      c_wr     = x_wr;
      c_idx    = x_idx;
      c_val    = x_val;
    end
  end

  always_comb begin
    state_nxt           = state_r;
    cur_nxt             = cur_r;
    pc_nxt              = pc_r;
    run_nxt             = run_r;
    rf_vld_nxt          = rf_vld_r;
    out_valid_nxt       = out_valid_r && out_stall;
    out_status_nxt      = out_status_r;
    out_stopped_nxt     = out_stopped_r;
    out_next_pc_nxt     = out_next_pc_r;
    out_reg_written_nxt = out_reg_written_r;
    out_reg_index_nxt   = out_reg_index_r;
    out_reg_value_nxt   = out_reg_value_r;
    pop                 = 1'b0;
    commit              = 1'b0;
    mem_ctl             = '0;
    case (state_r)
      S_ISSUE: begin
        if (hd_valid) begin
          pop       = 1'b1;
          cur_nxt   = hd;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (x_load) begin
          mem_ctl.rd_en = 1'b1;
          state_nxt     = S_LOAD;
        end else if (out_free) begin
          commit          = 1'b1;
          mem_ctl.wr_word = x_st;
          mem_ctl.wr_byte = x_pl;
          state_nxt       = S_ISSUE;
        end
      end
      S_LOAD: begin
        if (out_free) begin
          commit    = 1'b1;
          state_nxt = S_ISSUE;
        end
      end
      default: begin
        state_nxt = S_ISSUE;
      end
    endcase
    if (commit) begin
      pc_nxt              = c_pc;
      run_nxt             = c_run;
      out_valid_nxt       = 1'b1;
      out_status_nxt      = c_status;
      out_stopped_nxt     = !c_run;
      out_next_pc_nxt     = c_pc;
      out_reg_written_nxt = c_wr;
      out_reg_index_nxt   = c_idx;
      out_reg_value_nxt   = c_val;
      if (c_wr) begin
        rf_vld_nxt[c_idx] = 1'b1;
      end
    end
  end

  assign rf_we = commit && c_wr;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_ISSUE;
      pc_r        <= '0;
      run_r       <= 1'b1;
      rf_vld_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pc_r        <= pc_nxt;
      run_r       <= run_nxt;
      rf_vld_r    <= rf_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
    cur_r             <= cur_nxt;
    out_status_r      <= out_status_nxt;
    out_stopped_r     <= out_stopped_nxt;
    out_next_pc_r     <= out_next_pc_nxt;
    out_reg_written_r <= out_reg_written_nxt;
    out_reg_index_r   <= out_reg_index_nxt;
    out_reg_value_r   <= out_reg_value_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_stopped     = out_stopped_r;
  assign out_next_pc     = out_next_pc_r;
  assign out_reg_written = out_reg_written_r;
  assign out_reg_index   = out_reg_index_r;
  assign out_reg_value   = out_reg_value_r;

  `RDEC_ASSERT_NXT(a_run_sticky, clk, rst_n, !run_r, !run_r, "run flag set again")
  `RDEC_ASSERT_IMP(a_fault_stops, clk, rst_n, out_valid_r && (out_status_r != STAT_OK), out_stopped_r, "fault without stop")
  `RDEC_ASSERT_IMP(a_no_wr_zero, clk, rst_n, out_valid_r && !out_reg_written_r, (out_reg_index_r == '0) && (out_reg_value_r == '0), "register fields set without write")
  `RDEC_ASSERT_IMP(a_load_state, clk, rst_n, state_r == S_LOAD, cur_r.cls == CLS_LW, "load state without load")

endmodule

// File: rtl/core/risc_decode_execute_core.sv
// Execute core for a small 32-bit ISA. Each input word is either an
// instruction (the word found at the current PC, which the caller fetches
// using out_next_pc) or a preload that writes one byte of the byte-addressed,
// little-endian data memory of MEM_BYTES bytes; every word yields exactly one
// result word with status, stopped flag, next PC and the register write it
// made. A front stage classifies words into a two-entry queue, so the input
// keeps flowing while the execute stage works or the result waits on
// out_stall. The execute stage takes one word at a time through a register
// file read, then execute and write-back, and an LW also through the
// registered read of the data memory banks. After reset the data memory is
// zeroed by a clearing pass over all ceil(MEM_BYTES/4) rows, one row of the
// four byte banks per cycle; in_stall stays high until it is done. HALT, an
// unknown opcode, an out-of-bounds PC, load or store stop the core until
// reset; later instructions report status 6 and change nothing, while
// preloads are still written.
module risc_decode_execute_core import rdec_pkg::*; #(
  parameter int MEM_BYTES = 65536
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_item_kind,
  input  logic [31:0] in_instruction,
  input  logic [15:0] in_preload_address,
  input  logic [7:0]  in_preload_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_status,
  output logic        out_stopped,
  output logic [31:0] out_next_pc,
  output logic        out_reg_written,
  output logic [4:0]  out_reg_index,
  output logic [31:0] out_reg_value
);

  localparam int AW = $clog2(MEM_BYTES);

  // queue head between front and back
  logic          hd_valid;
  ent_t          hd;
  logic          pop;

  // data memory access from the execute stage
  dmem_ctl_t     mem_ctl;
  logic [AW-1:0] mem_addr;
  logic [31:0]   mem_wdata;
  logic [31:0]   mem_rdata;
  logic          mem_busy;

  // classify and queue words; hold the input while memory clears
  rdec_front u_front (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_item_kind       (in_item_kind),
    .in_instruction     (in_instruction),
    .in_preload_address (in_preload_address),
    .in_preload_byte    (in_preload_byte),
    .hold               (mem_busy),
    .hd_valid           (hd_valid),
    .hd                 (hd),
    .pop                (pop)
  );

  // execute one word at a time; register the result
  rdec_back #(
    .MEM_BYTES (MEM_BYTES)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .hd_valid        (hd_valid),
    .hd              (hd),
    .pop             (pop),
    .mem_ctl         (mem_ctl),
    .mem_addr        (mem_addr),
    .mem_wdata       (mem_wdata),
    .mem_rdata       (mem_rdata),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_status      (out_status),
    .out_stopped     (out_stopped),
    .out_next_pc     (out_next_pc),
    .out_reg_written (out_reg_written),
    .out_reg_index   (out_reg_index),
    .out_reg_value   (out_reg_value)
  );

  // four byte banks; unaligned words span two rows
  rdec_dmem #(
    .MEM_BYTES (MEM_BYTES)
  ) u_dmem (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (mem_ctl),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata),
    .busy  (mem_busy)
  );

endmodule

// File: test/tb_top.sv
module tb_top;
  import rdec_pkg::*;

  localparam int MEM_BYTES      = 65536;
  localparam int RANDOM_WORDS   = 1000;
  // Quiet cycles allowed on both channels; the clearing pass after reset
  // alone keeps the input stalled for its whole length.
  localparam int WATCHDOG_LIMIT = 60000;
  localparam int DRAIN_CYCLES   = 12;

  // One expected result word.
  typedef struct {
    logic [2:0]  status;
    logic        stopped;
    logic [31:0] next_pc;
    logic        reg_written;
    logic [4:0]  reg_index;
    logic [31:0] reg_value;
  } result_t;

  // Architectural copy of the core plus the queue of result words it owes.
  class core_result_board #(int BYTES = 65536);
    bit [31:0] pc;
    bit [31:0] regs [32];
    bit        running;
    bit [7:0]  mem [BYTES];
    result_t   expected_results [$];
    int        errors;

    function new();
      running = 1'b1;
      errors  = 0;
    endfunction

    function logic [31:0] sign_ext(logic [15:0] v);
      return {{16{v[15]}}, v};
    endfunction

    function bit in_range(logic [31:0] a);
      return a <= 32'(BYTES - 4);
    endfunction

    // Apply one accepted input word to the copy and queue its result.
    function void note_word(logic kind, logic [31:0] ins, logic [15:0] paddr,
                            logic [7:0] pbyte);
      result_t     r;
      logic [5:0]  op;
      logic [4:0]  rd, ra, rb;
      logic [15:0] imm;
      logic [31:0] ea;
      r.status      = STAT_OK;
      r.reg_written = 1'b0;
      r.reg_index   = 5'd0;
      r.reg_value   = 32'd0;
      op  = ins[31:26];
      rd  = ins[25:21];
      ra  = ins[20:16];
      rb  = ins[15:11];
      imm = ins[15:0];
      ea  = regs[ra] + sign_ext(imm);
      if (kind == KIND_PRELOAD) begin
        if (paddr < BYTES) mem[paddr] = pbyte;
      end else if (!running) begin
        r.status = STAT_STOPPED;
      end else if (!in_range(pc)) begin
        running  = 1'b0;
        r.status = STAT_PC_OOB;
      end else begin
        pc = pc + 32'd4;
        case (op)
          OP_NOP: ;
          OP_ADDI: r.reg_value = regs[ra] + sign_ext(imm);
          OP_ADD:  r.reg_value = regs[ra] + regs[rb];
          OP_SUB:  r.reg_value = regs[ra] - regs[rb];
          OP_MUL:  r.reg_value = regs[ra] * regs[rb];
          OP_ANDI: r.reg_value = regs[ra] & {16'd0, imm};
          OP_ORI:  r.reg_value = regs[ra] | {16'd0, imm};
          OP_BEQ:  if (regs[rd] == regs[ra]) pc = pc + (sign_ext(imm) << 2);
          OP_BNE:  if (regs[rd] != regs[ra]) pc = pc + (sign_ext(imm) << 2);
          OP_LW: begin
            if (in_range(ea)) begin
              r.reg_value = {mem[ea + 3], mem[ea + 2], mem[ea + 1], mem[ea]};
            end else begin
              running  = 1'b0;
              r.status = STAT_LD_OOB;
            end
          end
          OP_SW: begin
            if (in_range(ea)) begin
              mem[ea]     = regs[rd][7:0];
              mem[ea + 1] = regs[rd][15:8];
              mem[ea + 2] = regs[rd][23:16];
              mem[ea + 3] = regs[rd][31:24];
            end else begin
              running  = 1'b0;
              r.status = STAT_ST_OOB;
            end
          end
          OP_HALT: begin
            running  = 1'b0;
            r.status = STAT_HALT;
          end
          default: begin
            running  = 1'b0;
            r.status = STAT_BAD_OP;
          end
        endcase
        r.reg_written = (op inside {OP_ADDI, OP_ADD, OP_SUB, OP_MUL, OP_ANDI, OP_ORI}) ||
                        (op == OP_LW && r.status == STAT_OK);
        if (r.reg_written) begin
          r.reg_index = rd;
          regs[rd]    = r.reg_value;
        end
      end
      r.stopped = !running;
      r.next_pc = pc;
      expected_results.push_back(r);
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch: expected %h actual %h", $time, name, want, got);
        errors++;
      end
    endfunction

    // Match one accepted result word against the oldest expectation.
    function void check_word(logic [2:0] st, logic sp, logic [31:0] npc, logic wr,
                             logic [4:0] idx, logic [31:0] val);
      result_t want;
      if (expected_results.size() == 0) begin
        $display("%0t: result word with none expected: expected none actual status %0d",
                 $time, st);
        errors++;
        return;
      end
      want = expected_results.pop_front();
      compare_field("status", 32'(want.status), 32'(st));
      compare_field("stopped", 32'(want.stopped), 32'(sp));
      compare_field("next_pc", want.next_pc, npc);
      compare_field("reg_written", 32'(want.reg_written), 32'(wr));
      compare_field("reg_index", 32'(want.reg_index), 32'(idx));
      compare_field("reg_value", want.reg_value, val);
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic        in_item_kind;
  logic [31:0] in_instruction;
  logic [15:0] in_preload_address;
  logic [7:0]  in_preload_byte;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  out_status;
  logic        out_stopped;
  logic [31:0] out_next_pc;
  logic        out_reg_written;
  logic [4:0]  out_reg_index;
  logic [31:0] out_reg_value;

  int src_idle_pct   = 0;
  int sink_stall_pct = 0;
  int quiet_cycles   = 0;

  core_result_board #(MEM_BYTES) board;

  risc_decode_execute_core #(.MEM_BYTES(MEM_BYTES)) dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_item_kind       (in_item_kind),
    .in_instruction     (in_instruction),
    .in_preload_address (in_preload_address),
    .in_preload_byte    (in_preload_byte),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_status         (out_status),
    .out_stopped        (out_stopped),
    .out_next_pc        (out_next_pc),
    .out_reg_written    (out_reg_written),
    .out_reg_index      (out_reg_index),
    .out_reg_value      (out_reg_value)
  );

  // 12-unit clock, high half first after the initial low.
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Receiver back-pressure: redraw the stall at every falling edge so it
  // lands on every phase of the core's work.
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < sink_stall_pct);
  end

  // Sample the result channel at the rising edge and score each word taken.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      board.check_word(out_status, out_stopped, out_next_pc, out_reg_written,
                       out_reg_index, out_reg_value);
    end
  end

  // Watchdog: end the run when neither channel moves a word for too long.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no word moved for %0d cycles", $time, quiet_cycles);
      $display("FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic logic [31:0] enc(logic [5:0] op, logic [4:0] rd, logic [4:0] ra,
                                      logic [15:0] low);
    return {op, rd, ra, low};
  endfunction

  // Pick a branch offset whose target stays inside memory: half the time a
  // short hop around the current PC, otherwise anywhere.
  function automatic logic [15:0] branch_offset();
    int cur;
    int top;
    int tw;
    cur = int'((board.pc + 32'd4) >> 2);
    top = (MEM_BYTES - 4) / 4;
    tw  = cur + int'($urandom_range(16, 0)) - 8;
    if ($urandom_range(1) == 0 || tw < 0 || tw > top) tw = int'($urandom_range(top, 0));
    return 16'(tw - cur);
  endfunction

  // Preload targets cluster at both ends of memory, where loads also land.
  function automatic logic [15:0] pick_preload_address();
    case ($urandom_range(2))
      0:       return 16'($urandom_range(63, 0));
      1:       return 16'(MEM_BYTES - 1 - int'($urandom_range(63, 0)));
      default: return 16'($urandom);
    endcase
  endfunction

  // Present one input word at a falling edge, hold it until taken, then
  // update the predicted state. Returns at a falling edge.
  task automatic send_word(input logic kind, input logic [31:0] ins,
                           input logic [15:0] paddr, input logic [7:0] pbyte);
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid           <= 1'b1;
    in_item_kind       <= kind;
    in_instruction     <= ins;
    in_preload_address <= paddr;
    in_preload_byte    <= pbyte;
    do @(posedge clk); while (in_stall);
    board.note_word(kind, ins, paddr, pbyte);
    @(negedge clk);
  endtask

  // Preload fields carry noise on execute words, and the instruction on
  // preload words, so every port bit toggles.
  task automatic exec_word(input logic [31:0] ins);
    send_word(KIND_EXEC, ins, 16'($urandom), 8'($urandom));
  endtask

  task automatic preload_word(input logic [15:0] addr, input logic [7:0] val);
    send_word(KIND_PRELOAD, 32'($urandom), addr, val);
  endtask

  // One or two well-formed random words: they never stop the core, so the random
  // part keeps exercising the running state.
  task automatic send_random_word();
    logic [4:0]  rd, ra, rb;
    logic [15:0] imm;
    logic [5:0]  op;
    logic [31:0] base;
    longint      lo, hi, tgt;
    int          pick;
    rd   = 5'($urandom);
    ra   = 5'($urandom);
    rb   = 5'($urandom);
    imm  = 16'($urandom);
    pick = $urandom_range(99);
    if (pick < 12) begin
      preload_word(pick_preload_address(), 8'($urandom));
    end else if (board.pc > 32'(MEM_BYTES - 8)) begin
      // Last word of memory: falling through would walk off the end, so
      // take a branch back on a register compared with itself.
      exec_word(enc(OP_BEQ, ra, ra, branch_offset()));
    end else if (pick < 16) begin
      exec_word(enc(OP_NOP, rd, ra, imm));
    end else if (pick < 56) begin
      case ($urandom_range(5))
        0:       op = OP_ADDI;
        1:       op = OP_ADD;
        2:       op = OP_SUB;
        3:       op = OP_MUL;
        4:       op = OP_ANDI;
        default: op = OP_ORI;
      endcase
      exec_word(enc(op, rd, ra, imm));
    end else if (pick < 70) begin
      op = ($urandom_range(1) == 0) ? OP_BEQ : OP_BNE;
      if ($urandom_range(2) == 0) rd = ra;
      exec_word(enc(op, rd, ra, branch_offset()));
    end else begin
      op = ($urandom_range(1) == 0) ? OP_LW : OP_SW;
      // Shrink a wild base register first so an in-range offset exists.
      if (board.regs[ra] > 32'hFFFF) exec_word(enc(OP_ANDI, ra, rb, imm));
      if (board.pc <= 32'(MEM_BYTES - 8)) begin
        base = board.regs[ra];
        lo   = (base > 32'd32768) ? longint'(base) - 32768 : 0;
        hi   = longint'(base) + 32767;
        if (hi > MEM_BYTES - 4) hi = MEM_BYTES - 4;
        case ($urandom_range(3))
          0:       tgt = lo;
          1:       tgt = hi;
          2:       tgt = $urandom_range(32'(hi), 32'(lo));
          default: tgt = (lo > 63) ? lo : $urandom_range(63, 32'(lo));
        endcase
        exec_word(enc(op, rd, ra, 16'(tgt - longint'(base))));
      end
    end
  endtask

  initial begin
    logic [4:0]  stop_ra;
    logic [15:0] stop_imm;
    logic [5:0]  stop_op;
    int          stop_case;

    board              = new();
    rst_n              = 1'b0;
    in_valid           = 1'b0;
    in_item_kind       = KIND_EXEC;
    in_instruction     = 32'd0;
    in_preload_address = 16'd0;
    in_preload_byte    = 8'd0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed words: byte extremes at both ends of memory, immediate
    // extremes, every operation but HALT, unaligned load and store, branches taken
    // forward, taken backward and not taken, a NOP full of junk bits, and a
    // write to register 0.
    preload_word(16'h0000, 8'hFF);
    preload_word(16'h0001, 8'h00);
    preload_word(16'h0002, 8'h5A);
    preload_word(16'h0003, 8'h81);
    preload_word(16'hFFFF, 8'hFF);
    preload_word(16'hFFFC, 8'h01);
    exec_word(enc(OP_ADDI, 5'd1, 5'd0, 16'h7FFF));
    exec_word(enc(OP_ADDI, 5'd2, 5'd0, 16'h8000));
    exec_word(enc(OP_ADDI, 5'd31, 5'd2, 16'hFFFF));
    exec_word(enc(OP_ORI, 5'd3, 5'd2, 16'hFFFF));
    exec_word(enc(OP_ANDI, 5'd4, 5'd3, 16'hFFFF));
    exec_word(enc(OP_ADD, 5'd5, 5'd3, {5'd3, 11'd0}));
    exec_word(enc(OP_SUB, 5'd6, 5'd0, {5'd3, 11'd0}));
    exec_word(enc(OP_MUL, 5'd7, 5'd2, {5'd3, 11'd0}));
    exec_word(enc(OP_LW, 5'd8, 5'd0, 16'h0000));
    exec_word(enc(OP_LW, 5'd9, 5'd4, 16'hFFFD));
    exec_word(enc(OP_SW, 5'd3, 5'd1, 16'h0002));
    exec_word(enc(OP_LW, 5'd10, 5'd1, 16'h0000));
    exec_word(enc(OP_BEQ, 5'd3, 5'd3, 16'h0001));
    exec_word(enc(OP_BNE, 5'd3, 5'd3, 16'h0005));
    exec_word(enc(OP_BNE, 5'd1, 5'd2, 16'hFFFE));
    exec_word({OP_NOP, 26'h3FFFFFF});
    exec_word(enc(OP_ADDI, 5'd0, 5'd0, 16'hFFFF));

    // Random words in four idling phases: none, idle sender, stalling
    // receiver, both.
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0:       begin src_idle_pct = 0;  sink_stall_pct = 0;  end
        1:       begin src_idle_pct = 84; sink_stall_pct = 0;  end
        2:       begin src_idle_pct = 0;  sink_stall_pct = 84; end
        default: begin src_idle_pct = 35; sink_stall_pct = 35; end
      endcase
      for (int i = 0; i < RANDOM_WORDS / 4; i++) send_random_word();
    end

    // Stopping is final until reset, so end with one stop of a random kind,
    // then words that hit the stopped core.
    stop_ra   = 5'($urandom);
    stop_imm  = 16'($urandom);
    stop_case = $urandom_range(4);
    case (stop_case)
      0: exec_word(enc(OP_HALT, 5'($urandom), stop_ra, stop_imm));
      1: begin
        do stop_op = 6'($urandom);
        while (stop_op inside {OP_NOP, OP_ADDI, OP_ADD, OP_SUB, OP_MUL, OP_ANDI, OP_ORI,
                               OP_BEQ, OP_BNE, OP_LW, OP_SW, OP_HALT});
        exec_word(enc(stop_op, 5'($urandom), stop_ra, stop_imm));
      end
      2, 3: begin
        // Draw offsets until the effective address falls outside memory.
        while (board.in_range(board.regs[stop_ra] + board.sign_ext(stop_imm)))
          stop_imm = 16'($urandom);
        exec_word(enc((stop_case == 2) ? OP_LW : OP_SW, 5'($urandom), stop_ra, stop_imm));
      end
      default: begin
        // Branch off the end of memory, then execute at the bad PC.
        while (board.in_range(board.pc + 32'd4 + (board.sign_ext(stop_imm) << 2)))
          stop_imm = 16'($urandom);
        exec_word(enc(OP_BEQ, stop_ra, stop_ra, stop_imm));
        exec_word(32'($urandom));
      end
    endcase
    repeat (20) begin
      if ($urandom_range(1) == 0) exec_word(32'($urandom));
      else preload_word(pick_preload_address(), 8'($urandom));
    end

    // Drain: drop valid, wait for every owed word, then keep watching the result
    // channel so a stray extra word would still be caught.
    in_valid <= 1'b0;
    while (board.expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (board.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// File: risc_decode_execute_core.f
+incdir+rtl/core
rtl/core/rdec_pkg.sv
rtl/core/rdec_ram.sv
rtl/core/rdec_front.sv
rtl/core/rdec_dmem.sv
rtl/core/rdec_back.sv
rtl/core/risc_decode_execute_core.sv
test/tb_top.sv
